>>> hdl/masked_gf256_multiply_top_defines.svh
// Assertion macros for the masked GF(2^8) multiplier.
`ifndef MASKED_GF256_MULTIPLY_TOP_DEFINES_SVH
`define MASKED_GF256_MULTIPLY_TOP_DEFINES_SVH

`ifndef SYNTH
`define MGM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mgm assertion failed");
`define MGM_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mgm forbidden condition seen");
`else
`define MGM_ASSERT(label, prop)
`define MGM_ASSERT_NEVER(label, expr)
`endif

`endif

>>> hdl/mgm_pkg.sv
// Shared constants and GF(2^8) helper functions for the masked multiplier.
package mgm_pkg;

  localparam int unsigned MAX_LANES      = 4;
  localparam int unsigned SHARES_DEFAULT = 4;
  localparam int unsigned WORD_W         = 8 * MAX_LANES;
  localparam int unsigned RND_BYTES      = MAX_LANES * (MAX_LANES - 1) / 2;
  localparam int unsigned RND_W          = 8 * RND_BYTES;
  localparam int unsigned ORDER_W        = 2;
  localparam int unsigned CNT_W          = $clog2(MAX_LANES + 1);
  localparam int unsigned RIDX_W         = $clog2(RND_BYTES);
  localparam logic [8:0]  GF_POLY        = 9'h11B;
  localparam logic [7:0]  GF_TOP         = 8'h80;
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(1);

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] m;
    acc = '0;
    m   = x;
    for (int bit_idx = 0; bit_idx < 8; bit_idx++) begin
      if (y[bit_idx]) begin
        acc = acc ^ m;
      end
      if ((m & GF_TOP) != 8'h00) begin
        m = (m << 1) ^ GF_POLY[7:0];
      end else begin
        m = m << 1;
      end
    end
    return acc;
  endfunction

  // Position of pair (i, j), i < j, in outer-i inner-j order with n shares.
  function automatic logic [RIDX_W-1:0] rnd_idx(input logic [CNT_W-1:0] n,
                                                 input int i, input int j);
    int nn;
    int k;
    nn = int'(n);
    k  = ((i * (2 * nn - i - 1)) >> 1) + (j - i - 1);
    return RIDX_W'(k);
  endfunction

endpackage

>>> hdl/mgm_gadget.sv
// Combinational ISW multiplication gadget over the active shares.
module mgm_gadget #(
  parameter int unsigned Shares = mgm_pkg::SHARES_DEFAULT
) (
  input  logic [mgm_pkg::WORD_W-1:0] a_i,
  input  logic [mgm_pkg::WORD_W-1:0] b_i,
  input  logic [mgm_pkg::RND_W-1:0]  rnd_i,
  input  logic [mgm_pkg::CNT_W-1:0]  active_i,
  output logic [mgm_pkg::WORD_W-1:0] c_o
);
  import mgm_pkg::*;

  logic [7:0] a_b   [MAX_LANES];
  logic [7:0] b_b   [MAX_LANES];
  logic [7:0] rnd_b [RND_BYTES];
  logic [7:0] r_m   [MAX_LANES][MAX_LANES];
  logic [7:0] c_b   [MAX_LANES];

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      a_b[i] = a_i[8*i +: 8];
      b_b[i] = b_i[8*i +: 8];
    end
    for (int k = 0; k < RND_BYTES; k++) begin
      rnd_b[k] = rnd_i[8*k +: 8];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      for (int j = 0; j < MAX_LANES; j++) begin
        r_m[i][j] = '0;
      end
    end
    for (int i = 0; i < Shares; i++) begin
      for (int j = i + 1; j < Shares; j++) begin
        if (active_i > CNT_W'(j)) begin
          r_m[i][j] = rnd_b[rnd_idx(active_i, i, j)];
          r_m[j][i] = (r_m[i][j] ^ gf_mul(a_b[i], b_b[j])) ^ gf_mul(a_b[j], b_b[i]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      c_b[i] = '0;
      if ((i < Shares) && (active_i > CNT_W'(i))) begin
        c_b[i] = gf_mul(a_b[i], b_b[i]);
        for (int j = 0; j < MAX_LANES; j++) begin
          c_b[i] = c_b[i] ^ r_m[i][j];
        end
      end
      c_o[8*i +: 8] = c_b[i];
    end
  end

endmodule

>>> hdl/masked_gf256_multiply_top.sv
// Top level of the masked GF(2^8) multiplier with input and result registers.
//
// The input channel carries one word per multiplication: the Boolean shares
// of operands a and b, one byte per share, and six fresh random bytes. The
// output channel carries the shares of the product. Both channels use
// valid and stall; a word moves when valid is high and stall is low.
// The configuration register holds the masking order d, so that d + 1
// shares (at most Shares) are active; it is written through cfg_we_i and
// cfg_wdata_i, and the user must write it only while no word is in flight,
// which the block does not enforce. Inactive product bytes are zero. A
// word taken sits in the input register, passes the combinational ISW
// gadget and moves into the result register when that register is empty
// or its product is being taken, which raises out_valid_o. One word is
// taken every cycle while in_stall_o is low; the two registers form a
// pipeline that keeps taking words while a result waits. When the receiver
// stalls, the result holds, the input register fills, and then in_stall_o
// rises. Reset empties both registers and sets the masking order to one.
module masked_gf256_multiply_top #(
  parameter int unsigned Shares = mgm_pkg::SHARES_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mgm_pkg::ORDER_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mgm_pkg::WORD_W-1:0]  a_shares_i,
  input  logic [mgm_pkg::WORD_W-1:0]  b_shares_i,
  input  logic [mgm_pkg::RND_W-1:0]   random_bytes_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mgm_pkg::WORD_W-1:0]  c_shares_o
);
  import mgm_pkg::*;

  `include "masked_gf256_multiply_top_defines.svh"

  logic [ORDER_W-1:0] order_q, order_d;
  logic               s1_valid_q, s1_valid_d;
  logic [WORD_W-1:0]  a_q, b_q;
  logic [RND_W-1:0]   rnd_q;
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  c_q;
  logic [WORD_W-1:0]  c_d;
  logic [CNT_W-1:0]   active_cnt;
  logic               s1_adv;
  logic               in_acc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    order_d = cfg_we_i ? cfg_wdata_i : order_q;
    s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
    if ((CNT_W'(order_q) + CNT_W'(1)) > CNT_W'(Shares)) begin
      active_cnt = CNT_W'(Shares);
    end else begin
      active_cnt = CNT_W'(order_q) + CNT_W'(1);
    end
  end

  mgm_gadget #(
    .Shares (Shares)
  ) u_gadget (
    .a_i      (a_q),
    .b_i      (b_q),
    .rnd_i    (rnd_q),
    .active_i (active_cnt),
    .c_o      (c_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= ORDER_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      order_q     <= order_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q   <= a_shares_i;
      b_q   <= b_shares_i;
      rnd_q <= random_bytes_i;
    end
    if (s1_adv && s1_valid_q) begin
      c_q <= c_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign c_shares_o  = c_q;

  `MGM_ASSERT(a_stall_only_when_full, in_stall_o |-> (s1_valid_q && out_valid_q))
  `MGM_ASSERT(a_accept_fills_s1, (in_valid_i && !in_stall_o) |=> s1_valid_q)
  `MGM_ASSERT(a_s1_moves_on, (s1_valid_q && s1_adv) |=> out_valid_q)

endmodule

>>> test/testbench.sv
// Self-checking testbench for the masked GF(2^8) multiplier with random idling on both channels.
module testbench;

  localparam int unsigned LANES = mgm_pkg::SHARES_DEFAULT;

  class product_tracker;
    logic [mgm_pkg::ORDER_W-1:0] order;
    logic [mgm_pkg::WORD_W-1:0]  pending_products[$];
    int                          errors;

    function new();
      order  = mgm_pkg::ORDER_RESET;
      errors = 0;
    endfunction

    static function logic [7:0] field_product(logic [7:0] x, logic [7:0] y);
      logic [7:0] acc;
      acc = 8'h00;
      for (int b = 7; b >= 0; b--) begin
        acc = {acc[6:0], 1'b0} ^ (acc[7] ? mgm_pkg::GF_POLY[7:0] : 8'h00);
        if (y[b]) begin
          acc = acc ^ x;
        end
      end
      return acc;
    endfunction

    function logic [mgm_pkg::WORD_W-1:0] isw_product(logic [mgm_pkg::WORD_W-1:0] a,
                                                     logic [mgm_pkg::WORD_W-1:0] b,
                                                     logic [mgm_pkg::RND_W-1:0] rnd);
      logic [7:0]                 pair_r[LANES][LANES];
      logic [7:0]                 c;
      logic [mgm_pkg::WORD_W-1:0] res;
      int                         active;
      int                         k;
      active = int'(order) + 1;
      if (active > LANES) begin
        active = LANES;
      end
      res = '0;
      k   = 0;
      for (int i = 0; i < active; i++) begin
        for (int j = i + 1; j < active; j++) begin
          pair_r[i][j] = rnd[8*k +: 8];
          pair_r[j][i] = rnd[8*k +: 8] ^ field_product(a[8*i +: 8], b[8*j +: 8])
                         ^ field_product(a[8*j +: 8], b[8*i +: 8]);
          k++;
        end
      end
      for (int i = 0; i < active; i++) begin
        c = field_product(a[8*i +: 8], b[8*i +: 8]);
        for (int j = 0; j < active; j++) begin
          if (j != i) begin
            c = c ^ pair_r[i][j];
          end
        end
        res[8*i +: 8] = c;
      end
      return res;
    endfunction

    function void note_word(logic [mgm_pkg::WORD_W-1:0] a, logic [mgm_pkg::WORD_W-1:0] b,
                            logic [mgm_pkg::RND_W-1:0] rnd);
      pending_products.push_back(isw_product(a, b, rnd));
    endfunction

    function void check_product(logic [mgm_pkg::WORD_W-1:0] c);
      logic [mgm_pkg::WORD_W-1:0] want;
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected product word, expected none, actual c_shares %h", $time, c);
        errors++;
      end else begin
        want = pending_products.pop_front();
        if (c !== want) begin
          $display("%0t: c_shares mismatch, expected %h, actual %h", $time, want, c);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_products.size();
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [mgm_pkg::ORDER_W-1:0] cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [mgm_pkg::WORD_W-1:0]  a_shares_i = '0;
  logic [mgm_pkg::WORD_W-1:0]  b_shares_i = '0;
  logic [mgm_pkg::RND_W-1:0]   random_bytes_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [mgm_pkg::WORD_W-1:0]  c_shares_o;

  product_tracker book;
  int             idle_max = 11;
  int             stall_left = 0;

  masked_gf256_multiply_top #(.Shares(LANES)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .a_shares_i    (a_shares_i),
    .b_shares_i    (b_shares_i),
    .random_bytes_i(random_bytes_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .c_shares_o    (c_shares_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni && stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      book.check_product(c_shares_o);
      stall_left = $urandom_range(0, idle_max);
    end
  end

  task automatic send_word(input logic [mgm_pkg::WORD_W-1:0] a,
                           input logic [mgm_pkg::WORD_W-1:0] b,
                           input logic [mgm_pkg::RND_W-1:0] rnd);
    int gap;
    gap = $urandom_range(0, idle_max);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    a_shares_i     = a;
    b_shares_i     = b;
    random_bytes_i = rnd;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    book.note_word(a, b, rnd);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_order(input logic [mgm_pkg::ORDER_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(posedge clk_i);
    book.order = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [mgm_pkg::WORD_W-1:0] shares_word();
    logic [mgm_pkg::WORD_W-1:0] w;
    w = $urandom;
    if ($urandom_range(0, 5) == 0) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0: w[8*i +: 8] = 8'h00;
          1: w[8*i +: 8] = 8'hFF;
          2: w[8*i +: 8] = 8'h80;
          default: w[8*i +: 8] = 8'h01;
        endcase
      end
    end
    return w;
  endfunction

  function automatic logic [mgm_pkg::RND_W-1:0] fresh_bytes();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic directed_words();
    send_word(32'h0000_0000, 32'h0000_0000, 48'h0000_0000_0000);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_word(32'h8080_8080, 32'h0202_0202, 48'h0000_0000_0000);
    send_word(32'h0102_0408, 32'h1020_4080, 48'h0123_4567_89AB);
    send_word(32'hA5C3_5A3C, 32'h0101_0101, 48'hFFFF_FFFF_FFFF);
    send_word(shares_word(), shares_word(), fresh_bytes());
  endtask

  task automatic random_phase(input logic [mgm_pkg::ORDER_W-1:0] value, input int count);
    drain();
    write_order(value);
    for (int n = 0; n < count; n++) begin
      idle_max = (n >= count / 3 && n < count / 3 + 15) ? 0 : 11;
      send_word(shares_word(), shares_word(), fresh_bytes());
    end
    idle_max = 11;
  endtask

  initial begin
    book = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_words();
    drain();
    write_order(2'd0);
    directed_words();
    drain();
    write_order(2'd2);
    directed_words();
    drain();
    write_order(2'd3);
    directed_words();

    random_phase(2'd3, 56);
    random_phase(2'd0, 56);
    random_phase(2'd2, 56);
    random_phase(2'd1, 56);
    random_phase(2'd3, 56);
    random_phase(2'd2, 56);
    random_phase(2'd0, 56);
    random_phase(2'd1, 56);

    drain();
    repeat (8) @(posedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("** masked_gf256_multiply_top: PASSED **");
    end else begin
      $display("** masked_gf256_multiply_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** masked_gf256_multiply_top: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/mgm_pkg.sv
hdl/mgm_gadget.sv
hdl/masked_gf256_multiply_top.sv
test/testbench.sv
